// ===== rtl/core/sprs_pkg.sv =====
// shared types and constants for the spectrum phase ramp shifter
package sprs_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd2;

  // field widths
  localparam int BIN_W   = 10;
  localparam int SMP_W   = 24;
  localparam int TURN_W  = 32;
  localparam int GAIN_W  = 20;
  localparam int CRD_W   = 32;
  localparam int STEPS   = 24;

  // reset value of the reciprocal gain, unity in Q4.16
  localparam logic [GAIN_W-1:0] GAIN_ONE = 20'd65536;

  // start vector of the rotation, gain compensated, Q2.30
  localparam logic signed [CRD_W-1:0] CORDIC_K = 32'sd652032874;

  // quadrant codes from the top two angle bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // rotation state handed from cell to cell
  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [1:0]              quad;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
  } rot_t;

  // round-down atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [CRD_W-1:0] atan_turns(input int step);
    logic signed [CRD_W-1:0] v;
    unique case (step)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933405;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335086;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41721;
      15: v = 32'sd20860;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2607;
      19: v = 32'sd1303;
      20: v = 32'sd651;
      21: v = 32'sd325;
      22: v = 32'sd162;
      23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/sprs_angle.sv =====
// front stage: per-bin angle k*theta and start vector of the rotation
module sprs_angle (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [sprs_pkg::BIN_W-1:0]            bin_number,
  input  logic signed [sprs_pkg::SMP_W-1:0]     re_in,
  input  logic signed [sprs_pkg::SMP_W-1:0]     im_in,
  input  logic [sprs_pkg::TURN_W-1:0]           theta,
  output logic                                  dn_valid,
  output sprs_pkg::rot_t                        dn_data,
  input  logic                                  dn_ready
);

  logic [sprs_pkg::BIN_W+sprs_pkg::TURN_W-1:0] prod;
  logic [sprs_pkg::TURN_W-1:0]                 ang;
  sprs_pkg::rot_t                              data_nxt;
  sprs_pkg::rot_t                              data_r;
  logic                                        vld_r;

  // angle wraps modulo one turn
  assign prod = {{sprs_pkg::TURN_W{1'b0}}, bin_number} *
                {{sprs_pkg::BIN_W{1'b0}}, theta};
  assign ang  = prod[sprs_pkg::TURN_W-1:0];

  // start vector, residual angle from the low 30 bits
  always_comb begin
    data_nxt.x    = sprs_pkg::CORDIC_K;
    data_nxt.y    = '0;
    data_nxt.z    = {2'b00, ang[sprs_pkg::TURN_W-3:0]};
    data_nxt.quad = ang[sprs_pkg::TURN_W-1 -: 2];
    data_nxt.re   = re_in;
    data_nxt.im   = im_in;
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/sprs_cell.sv =====
// one rotation step of the cordic chain
module sprs_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  sprs_pkg::rot_t up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output sprs_pkg::rot_t dn_data,
  input  logic           dn_ready
);

  localparam logic signed [sprs_pkg::CRD_W-1:0] ATAN = sprs_pkg::atan_turns(STEP);

  logic signed [sprs_pkg::CRD_W-1:0] dx;
  logic signed [sprs_pkg::CRD_W-1:0] dy;
  sprs_pkg::rot_t                    data_nxt;
  sprs_pkg::rot_t                    data_r;
  logic                              vld_r;

  // micro-rotation toward zero residual angle
  always_comb begin
    dx       = up_data.y >>> STEP;
    dy       = up_data.x >>> STEP;
    data_nxt = up_data;
    if (!up_data.z[sprs_pkg::CRD_W-1]) begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - ATAN;
    end else begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + ATAN;
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/sprs_scale.sv =====
// back end: quadrant fix, complex multiply, rounding, gain and saturation
module sprs_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  input  sprs_pkg::rot_t                    up_data,
  output logic                              up_ready,
  input  logic [sprs_pkg::GAIN_W-1:0]       gain,
  output logic                              out_valid,
  output logic signed [sprs_pkg::SMP_W-1:0] re_out,
  output logic signed [sprs_pkg::SMP_W-1:0] im_out,
  input  logic                              out_stall
);

  localparam int PROD_W = sprs_pkg::SMP_W + sprs_pkg::CRD_W;   // 56
  localparam int SUM_W  = PROD_W + 1;                           // 57
  localparam int T_W    = SUM_W - 22;                           // 35
  localparam int G_W    = T_W + sprs_pkg::GAIN_W + 1;           // 56
  localparam int U_W    = G_W - 24;                             // 32

  localparam logic signed [SUM_W-1:0] RND_T = SUM_W'(2097152);
  localparam logic signed [G_W-1:0]   RND_U = G_W'(8388608);
  localparam logic signed [U_W-1:0]   SAT_HI = U_W'(8388607);
  localparam logic signed [U_W-1:0]   SAT_LO = -U_W'(8388608);

  logic signed [sprs_pkg::CRD_W-1:0] cs;
  logic signed [sprs_pkg::CRD_W-1:0] sn;

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic signed [PROD_W-1:0] rc_r, is_r, ic_r, rs_r;
  logic signed [SUM_W-1:0]  pr, pi;
  logic signed [SUM_W-1:0]  pr_rnd, pi_rnd;
  logic signed [T_W-1:0]    tr_r, ti_r;
  logic signed [G_W-1:0]    gr_r, gi_r;
  logic signed [G_W-1:0]    gr_rnd, gi_rnd;
  logic signed [U_W-1:0]    ur, ui;
  logic signed [sprs_pkg::SMP_W-1:0] re_nxt, im_nxt;
  logic signed [sprs_pkg::SMP_W-1:0] re_r, im_r;

  // ready ripples back through the stages
  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // quadrant applied by swap and negate
  always_comb begin
    unique case (up_data.quad)
      sprs_pkg::QUAD_0: begin cs = up_data.x;  sn = up_data.y;  end
      sprs_pkg::QUAD_1: begin cs = -up_data.y; sn = up_data.x;  end
      sprs_pkg::QUAD_2: begin cs = -up_data.x; sn = -up_data.y; end
      sprs_pkg::QUAD_3: begin cs = up_data.y;  sn = -up_data.x; end
      default:          begin cs = up_data.x;  sn = up_data.y;  end
    endcase
  end

  // sum of products with rounding to eight fraction bits
  always_comb begin
    pr     = {rc_r[PROD_W-1], rc_r} + {is_r[PROD_W-1], is_r};
    pi     = {ic_r[PROD_W-1], ic_r} - {rs_r[PROD_W-1], rs_r};
    pr_rnd = pr + RND_T;
    pi_rnd = pi + RND_T;
  end

  // gain rounding half up, then saturation
  always_comb begin
    gr_rnd = gr_r + RND_U;
    gi_rnd = gi_r + RND_U;
    ur     = gr_rnd[G_W-1:24];
    ui     = gi_rnd[G_W-1:24];
    if (ur > SAT_HI) begin
      re_nxt = SAT_HI[sprs_pkg::SMP_W-1:0];
    end else if (ur < SAT_LO) begin
      re_nxt = SAT_LO[sprs_pkg::SMP_W-1:0];
    end else begin
      re_nxt = ur[sprs_pkg::SMP_W-1:0];
    end
    if (ui > SAT_HI) begin
      im_nxt = SAT_HI[sprs_pkg::SMP_W-1:0];
    end else if (ui < SAT_LO) begin
      im_nxt = SAT_LO[sprs_pkg::SMP_W-1:0];
    end else begin
      im_nxt = ui[sprs_pkg::SMP_W-1:0];
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy1) begin
      rc_r <= up_data.re * cs;
      is_r <= up_data.im * sn;
      ic_r <= up_data.im * cs;
      rs_r <= up_data.re * sn;
    end
    if (rdy2) begin
      tr_r <= pr_rnd[SUM_W-1:22];
      ti_r <= pi_rnd[SUM_W-1:22];
    end
    if (rdy3) begin
      gr_r <= tr_r * $signed({1'b0, gain});
      gi_r <= ti_r * $signed({1'b0, gain});
    end
    if (rdy4) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end

  assign out_valid = v4_r;
  assign re_out    = re_r;
  assign im_out    = im_r;

endmodule

// ===== rtl/core/spectrum_phase_ramp_shift.sv =====
// top level of the spectrum phase ramp shifter
//
// Each request on the input channel carries one complex spectrum bin
// (in_re_in, in_im_in) and its bin number in_bin_number. The block rotates
// the bin by exp(-j*2*pi*k*theta), theta = phase_turns + rotate_turns in
// turns, scales by gain_recip (Q4.16) and saturates to 24 bits.
// Configuration writes on cfg_*: index 0 phase_turns, 1 rotate_turns,
// 2 gain_recip; other indexes are ignored. cfg_ready is always high.
// The pipeline is one angle stage, a chain of 24 cordic cells, and one
// stage each for the complex multiply, rounding, gain multiply and the
// output register. One request per cycle is taken and one result per cycle
// leaves while out_stall is low; the 24-cell cordic chain sets the depth.
// Every stage has its own valid flag, so a stalled output only backs up the
// chain once every stage holds a request; until then in_stall stays low.
// Reset clears all valid flags and returns the registers to phase 0,
// rotation 0 and unity gain.
module spectrum_phase_ramp_shift (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [sprs_pkg::BIN_W-1:0]             in_bin_number,
  input  logic signed [sprs_pkg::SMP_W-1:0]      in_re_in,
  input  logic signed [sprs_pkg::SMP_W-1:0]      in_im_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sprs_pkg::SMP_W-1:0]      out_re_out,
  output logic signed [sprs_pkg::SMP_W-1:0]      out_im_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sprs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sprs_pkg::TURN_W-1:0]            cfg_data
);

  logic [sprs_pkg::TURN_W-1:0] phase_r;
  logic [sprs_pkg::TURN_W-1:0] rotate_r;
  logic [sprs_pkg::TURN_W-1:0] theta_r;
  logic [sprs_pkg::GAIN_W-1:0] gain_r;
  logic                        cfg_wr;

  logic                        front_ready;
  logic                        chain_valid [sprs_pkg::STEPS+1];
  logic                        chain_ready [sprs_pkg::STEPS+1];
  sprs_pkg::rot_t              chain_data  [sprs_pkg::STEPS+1];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration registers; theta kept as a ready-made sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      rotate_r <= '0;
      theta_r  <= '0;
      gain_r   <= sprs_pkg::GAIN_ONE;
    end else if (cfg_wr) begin
      if (cfg_index == sprs_pkg::REG_PHASE) begin
        phase_r <= cfg_data;
        theta_r <= cfg_data + rotate_r;
      end else if (cfg_index == sprs_pkg::REG_ROTATE) begin
        rotate_r <= cfg_data;
        theta_r  <= phase_r + cfg_data;
      end else if (cfg_index == sprs_pkg::REG_GAIN) begin
        gain_r <= cfg_data[sprs_pkg::GAIN_W-1:0];
      end
    end
  end

  // angle stage
  sprs_angle u_angle (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (front_ready),
    .bin_number (in_bin_number),
    .re_in      (in_re_in),
    .im_in      (in_im_in),
    .theta      (theta_r),
    .dn_valid   (chain_valid[0]),
    .dn_data    (chain_data[0]),
    .dn_ready   (chain_ready[0])
  );

  assign in_stall = !front_ready;

  // cordic chain
  for (genvar g = 0; g < sprs_pkg::STEPS; g++) begin : g_cell
    sprs_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[g]),
      .up_data  (chain_data[g]),
      .up_ready (chain_ready[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_data  (chain_data[g+1]),
      .dn_ready (chain_ready[g+1])
    );
  end

  // multiply, round, gain, saturate
  sprs_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (chain_valid[sprs_pkg::STEPS]),
    .up_data   (chain_data[sprs_pkg::STEPS]),
    .up_ready  (chain_ready[sprs_pkg::STEPS]),
    .gain      (gain_r),
    .out_valid (out_valid),
    .re_out    (out_re_out),
    .im_out    (out_im_out),
    .out_stall (out_stall)
  );

  // theta always equals the sum of its two registers
  a_theta_sum: assert property (@(posedge clk) disable iff (!rst_n)
    theta_r == phase_r + rotate_r)
    else $error("theta out of step with phase and rotate registers");

  // the input backs up only when the output is held
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not held");

  // a full chain with the output free takes the next request
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

// ===== bench/tb_spectrum_phase_ramp_shift.sv =====
// self-checking bench for the spectrum phase ramp shifter, random and directed bins
module tb_spectrum_phase_ramp_shift;

  localparam int LIMIT       = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RAND_SETS   = 12;
  localparam int BINS_PER_SET = 155;
  localparam logic [sprs_pkg::CFG_IDX_W-1:0] REG_UNUSED = sprs_pkg::REG_GAIN + 8'd1;
  localparam logic [sprs_pkg::CFG_IDX_W-1:0] REG_TOP    = {sprs_pkg::CFG_IDX_W{1'b1}};

  // arctangent steps in units of 2^-32 turn
  localparam longint ARC_TURNS [0:sprs_pkg::STEPS-1] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  typedef struct packed {
    logic [sprs_pkg::BIN_W-1:0]        k;
    logic signed [sprs_pkg::SMP_W-1:0] re;
    logic signed [sprs_pkg::SMP_W-1:0] im;
  } bin_req_t;

  typedef struct packed {
    logic signed [sprs_pkg::SMP_W-1:0] re;
    logic signed [sprs_pkg::SMP_W-1:0] im;
  } shifted_bin_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [sprs_pkg::BIN_W-1:0]        in_bin_number = '0;
  logic signed [sprs_pkg::SMP_W-1:0] in_re_in = '0;
  logic signed [sprs_pkg::SMP_W-1:0] in_im_in = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [sprs_pkg::SMP_W-1:0] out_re_out;
  logic signed [sprs_pkg::SMP_W-1:0] out_im_out;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sprs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [sprs_pkg::TURN_W-1:0]       cfg_data = '0;

  // predictor copy of the registers
  logic [sprs_pkg::TURN_W-1:0] phase_cfg = '0;
  logic [sprs_pkg::TURN_W-1:0] rotate_cfg = '0;
  logic [sprs_pkg::GAIN_W-1:0] gain_cfg = sprs_pkg::GAIN_ONE;

  bin_req_t     bin_queue[$];
  shifted_bin_t shifted_bins[$];
  bin_req_t     next_bin;
  shifted_bin_t want;

  int bins_queued = 0;
  int bins_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  spectrum_phase_ramp_shift DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bin_number (in_bin_number),
    .in_re_in      (in_re_in),
    .in_im_in      (in_im_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_re_out    (out_re_out),
    .out_im_out    (out_im_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // round Q.30 product to 8 fraction bits, apply gain, saturate
  function automatic logic signed [sprs_pkg::SMP_W-1:0] gain_and_clip(input longint p);
    longint t;
    longint u;
    t = (p + 64'sd2097152) >>> 22;
    u = (t * longint'({44'd0, gain_cfg}) + 64'sd8388608) >>> 24;
    if (u > 64'sd8388607) u = 64'sd8388607;
    if (u < -64'sd8388608) u = -64'sd8388608;
    return u[sprs_pkg::SMP_W-1:0];
  endfunction

  // rotate one bin by -k*theta and scale it
  function automatic shifted_bin_t predict_shift(
    input logic [sprs_pkg::BIN_W-1:0]        k,
    input logic signed [sprs_pkg::SMP_W-1:0] re,
    input logic signed [sprs_pkg::SMP_W-1:0] im
  );
    logic [sprs_pkg::TURN_W-1:0] theta;
    logic [sprs_pkg::TURN_W-1:0] ang;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    longint re_l;
    longint im_l;
    shifted_bin_t r;
    theta = phase_cfg + rotate_cfg;
    ang = theta * {{(sprs_pkg::TURN_W-sprs_pkg::BIN_W){1'b0}}, k};
    x = longint'(sprs_pkg::CORDIC_K);
    y = 0;
    z = longint'({34'd0, ang[29:0]});
    for (int i = 0; i < sprs_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURNS[i];
      end
    end
    // exact quadrant fold
    case (ang[31:30])
      sprs_pkg::QUAD_0: begin c = x;  s = y;  end
      sprs_pkg::QUAD_1: begin c = -y; s = x;  end
      sprs_pkg::QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    re_l = longint'(re);
    im_l = longint'(im);
    r.re = gain_and_clip(re_l * c + im_l * s);
    r.im = gain_and_clip(im_l * c - re_l * s);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        shifted_bins.push_back(predict_shift(in_bin_number, in_re_in, in_im_in));
        bins_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bin_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_bin = bin_queue.pop_front();
          in_valid      <= 1'b1;
          in_bin_number <= next_bin.k;
          in_re_in      <= next_bin.re;
          in_im_in      <= next_bin.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (shifted_bins.size() == 0) begin
          $error("result with nothing expected: re_out=%0d im_out=%0d",
                 out_re_out, out_im_out);
          mismatches++;
        end else begin
          want = shifted_bins.pop_front();
          if (out_re_out !== want.re) begin
            $error("re_out mismatch: expected %0d, got %0d", want.re, out_re_out);
            mismatches++;
          end
          if (out_im_out !== want.im) begin
            $error("im_out mismatch: expected %0d, got %0d", want.im, out_im_out);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_bin(input logic [sprs_pkg::BIN_W-1:0] k,
                           input logic signed [sprs_pkg::SMP_W-1:0] re,
                           input logic signed [sprs_pkg::SMP_W-1:0] im);
    bin_req_t b;
    b.k = k;
    b.re = re;
    b.im = im;
    bin_queue.push_back(b);
    bins_queued++;
  endtask

  // wait until every request is taken and every result is back
  task automatic wait_idle();
    while (bins_taken != bins_queued || shifted_bins.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write on the cfg channel, mirrored into the predictor
  task automatic write_reg(input logic [sprs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sprs_pkg::TURN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sprs_pkg::REG_PHASE:  phase_cfg = val;
      sprs_pkg::REG_ROTATE: rotate_cfg = val;
      sprs_pkg::REG_GAIN:   gain_cfg = val[sprs_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [sprs_pkg::SMP_W-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      7: return sprs_pkg::SMP_W'($signed($urandom_range(255)) - 128);
      8: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      9: return '0;
      default: return r[sprs_pkg::SMP_W-1:0];
    endcase
  endfunction

  function automatic logic [sprs_pkg::TURN_W-1:0] rand_turns();
    case ($urandom_range(3))
      2: return $urandom_range(2097152) - 32'd1048576;
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [sprs_pkg::TURN_W-1:0] rand_gain_word();
    logic [sprs_pkg::TURN_W-1:0] w;
    w = $urandom();
    case ($urandom_range(3))
      0: w[sprs_pkg::GAIN_W-1:0] = sprs_pkg::GAIN_W'($urandom_range(1048575));
      1: w[sprs_pkg::GAIN_W-1:0] = sprs_pkg::GAIN_W'($urandom_range(69632, 61440));
      2: w[sprs_pkg::GAIN_W-1:0] = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
      default: w[sprs_pkg::GAIN_W-1:0] = sprs_pkg::GAIN_W'($urandom_range(131071));
    endcase
    return w;
  endfunction

  // stimulus and end of run
  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 7;
    recv_stall_pct = 70;

    // reset settings: zero angle, unity gain, field extremes and zero bin
    queue_bin(10'd0, 24'sd0, 24'sd0);
    queue_bin(10'd0, 24'sh7FFFFF, 24'sh800000);
    queue_bin(10'd512, 24'sh800000, 24'sh7FFFFF);
    queue_bin(10'd1023, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_bin(10'd1, -24'sd1, 24'sd1);
    queue_bin(10'd1023, 24'sd0, 24'sd0);
    wait_idle();

    // theta one step short of a full turn, widest gain with junk above bit 19
    write_reg(sprs_pkg::REG_PHASE, 32'h8000_0000);
    write_reg(sprs_pkg::REG_ROTATE, 32'h7FFF_FFFF);
    write_reg(sprs_pkg::REG_GAIN, 32'hFFFF_FFFF);
    settings_used++;
    queue_bin(10'd0, 24'sh7FFFFF, 24'sh800000);
    queue_bin(10'd1, 24'sh800000, 24'sh800000);
    queue_bin(10'd512, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_bin(10'd1023, 24'sd1000, -24'sd1000);
    queue_bin(10'd700, 24'sd0, 24'sd0);
    wait_idle();

    // zero gain, theta two steps short of a full turn
    write_reg(sprs_pkg::REG_PHASE, 32'h7FFF_FFFF);
    write_reg(sprs_pkg::REG_ROTATE, 32'h7FFF_FFFF);
    write_reg(sprs_pkg::REG_GAIN, 32'h0000_0000);
    settings_used++;
    queue_bin(10'd1023, 24'sh7FFFFF, 24'sh800000);
    queue_bin(10'd3, 24'sd12345, -24'sd54321);
    wait_idle();

    // quarter turn per bin walks all quadrants, unused indexes ignored
    write_reg(sprs_pkg::REG_PHASE, 32'h4000_0000);
    write_reg(sprs_pkg::REG_ROTATE, 32'h0000_0000);
    write_reg(sprs_pkg::REG_GAIN, {12'd0, sprs_pkg::GAIN_ONE});
    write_reg(REG_UNUSED, $urandom());
    write_reg(REG_TOP, $urandom());
    settings_used++;
    queue_bin(10'd0, 24'sd3000000, 24'sd1000000);
    queue_bin(10'd1, 24'sd3000000, 24'sd1000000);
    queue_bin(10'd2, 24'sd3000000, 24'sd1000000);
    queue_bin(10'd3, 24'sd3000000, 24'sd1000000);
    queue_bin(10'd5, 24'sh800000, 24'sh800000);
    wait_idle();

    // random register settings and bins, idling pattern changes per third
    for (int p = 0; p < RAND_SETS; p++) begin
      case (p / (RAND_SETS / 3))
        0: begin send_idle_pct = 7;  recv_stall_pct = 70; end
        1: begin send_idle_pct = 70; recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(sprs_pkg::REG_PHASE, rand_turns());
      write_reg(sprs_pkg::REG_ROTATE, rand_turns());
      write_reg(sprs_pkg::REG_GAIN, rand_gain_word());
      if ($urandom_range(3) == 0) begin
        write_reg(sprs_pkg::CFG_IDX_W'($urandom_range(REG_TOP, REG_UNUSED)), $urandom());
      end
      settings_used++;
      n = BINS_PER_SET / 2;
      for (int i = 0; i < BINS_PER_SET; i++) begin
        queue_bin(sprs_pkg::BIN_W'($urandom_range(1023)), rand_sample(), rand_sample());
        // hold off mid-set until the pipe is empty
        if (i == n) wait_idle();
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("summary: %0d bins sent, %0d results checked over %0d register settings",
             bins_taken, results_seen, settings_used);
    $display("summary: %0d mismatches, %0d results still owed", mismatches,
             shifted_bins.size());
    if (mismatches == 0 && shifted_bins.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
